@@ design/dfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame receiver package
// Types, character codes and sizing shared by the receiver modules.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int BUFFER_DEPTH    = 1024;
  localparam int ADDR_W          = $clog2(BUFFER_DEPTH);
  localparam int WRITE_ADDRESS_W = 10;

  localparam logic [ADDR_W-1:0] LAST_ADDRESS = ADDR_W'(BUFFER_DEPTH - 1);

  localparam logic       MODE_BYTE    = 1'b0;
  localparam logic       MODE_RELEASE = 1'b1;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;
  localparam logic [7:0] CHAR_LANGLE = 8'h3C;
  localparam logic [7:0] CHAR_RANGLE = 8'h3E;
  localparam logic [7:0] CHAR_BANG   = 8'h21;

  typedef enum logic [2:0] {
    KIND_IDLE   = 3'd0,
    KIND_DOLLAR = 3'd1,
    KIND_HASH   = 3'd2,
    KIND_BRACE  = 3'd3,
    KIND_ANGLE  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] next_address;
    logic              pending;
  } dfr_state_t;

  typedef struct packed {
    logic                       stored;
    logic [WRITE_ADDRESS_W-1:0] write_address;
    logic [7:0]                 data_byte;
    logic                       frame_complete;
    logic [2:0]                 frame_kind_out;
    logic                       frame_pending;
  } dfr_result_t;

endpackage

@@ design/dfr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame receiver channels
// Valid/ready channels for received byte requests and for results.
// ----------------------------------------------------------------------------
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface dfr_out_if;
  logic       valid;
  logic       ready;
  logic       stored;
  logic [9:0] write_address;
  logic [7:0] data_byte;
  logic       frame_complete;
  logic [2:0] frame_kind_out;
  logic       frame_pending;

  modport source (output valid, output stored, output write_address, output data_byte,
                  output frame_complete, output frame_kind_out, output frame_pending,
                  input ready);
  modport sink   (input valid, input stored, input write_address, input data_byte,
                  input frame_complete, input frame_kind_out, input frame_pending,
                  output ready);
endinterface

@@ design/dfr_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame receiver framing logic
// Works out the next framing state and the result for one request.
// ----------------------------------------------------------------------------
module dfr_framer import dfr_pkg::*; (
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  input  dfr_state_t  state,
  output dfr_state_t  state_next,
  output dfr_result_t result
);

  kind_t                             kind;
  logic [ADDR_W-1:0]                 addr;
  logic                              done;
  logic [ADDR_W+WRITE_ADDRESS_W-1:0] addr_wide;

  always_comb begin
    kind = state.kind;
    addr = state.next_address;
    if (rx_byte == CHAR_LANGLE) begin
      kind = KIND_ANGLE;
      addr = '0;
    end else if (state.kind == KIND_IDLE) begin
      case (rx_byte)
        CHAR_DOLLAR: kind = KIND_DOLLAR;
        CHAR_HASH:   kind = KIND_HASH;
        CHAR_LBRACE: kind = KIND_BRACE;
        default:     kind = KIND_IDLE;
      endcase
      addr = '0;
    end
    done = ((kind == KIND_ANGLE) && (rx_byte == CHAR_RANGLE)) ||
           (((kind == KIND_DOLLAR) || (kind == KIND_HASH)) && (rx_byte == CHAR_BANG)) ||
           ((kind == KIND_BRACE) && (rx_byte == CHAR_RBRACE));
    addr_wide = {{WRITE_ADDRESS_W{1'b0}}, addr};
  end

  always_comb begin
    state_next            = state;
    result                = '0;
    result.frame_kind_out = state.kind;
    result.frame_pending  = state.pending;
    if (mode == MODE_RELEASE) begin
      state_next.pending    = 1'b0;
      state_next.kind       = KIND_IDLE;
      result.frame_kind_out = KIND_IDLE;
      result.frame_pending  = 1'b0;
    end else if (!state.pending) begin
      state_next.kind         = kind;
      state_next.next_address = (addr == LAST_ADDRESS) ? '0 : addr + 1'b1;
      state_next.pending      = done;
      result.stored           = 1'b1;
      result.write_address    = addr_wide[WRITE_ADDRESS_W-1:0];
      result.data_byte        = rx_byte;
      result.frame_complete   = done;
      result.frame_kind_out   = kind;
      result.frame_pending    = done;
    end
  end

endmodule

@@ design/delimited_frame_receiver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame receiver
// Frames received bytes by start and end characters and reports each stored
// byte with its buffer write address.
//
//   Channel   Direction  Payload
//   rx_req    sink       mode, rx_byte
//   frame_res source     stored, write_address, data_byte, frame_complete,
//                        frame_kind_out, frame_pending
//
// One request is taken per cycle while the skid register is empty; each
// request gives exactly one result, held in the output or skid register.
// A two-entry result buffer (output register and skid register) sets the
// rate: requests are taken while the skid register is empty.
// Synchronous reset returns the framer to idle at address 0, empties the
// result buffer and holds requests off while it is asserted.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_top import dfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dfr_in_if.sink    rx_req,
  dfr_out_if.source frame_res
);

  dfr_state_t  state;
  dfr_state_t  state_next;
  dfr_result_t result;
  dfr_result_t out_data;
  dfr_result_t skid_data;
  logic        out_valid;
  logic        skid_valid;
  logic        push;
  logic        pop;

  dfr_framer u_framer (
    .mode       (rx_req.mode),
    .rx_byte    (rx_req.rx_byte),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  assign rx_req.ready = !skid_valid && !rst;
  assign push         = rx_req.valid && rx_req.ready;
  assign pop          = out_valid && frame_res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.kind         <= KIND_IDLE;
      state.next_address <= '0;
      state.pending      <= 1'b0;
    end else if (push) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= result;
        end
      end else if (push) begin
        out_data <= result;
      end
    end else if (push) begin
      skid_data <= result;
    end
  end

  assign frame_res.valid          = out_valid;
  assign frame_res.stored         = out_data.stored;
  assign frame_res.write_address  = out_data.write_address;
  assign frame_res.data_byte      = out_data.data_byte;
  assign frame_res.frame_complete = out_data.frame_complete;
  assign frame_res.frame_kind_out = out_data.frame_kind_out;
  assign frame_res.frame_pending  = out_data.frame_pending;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame receiver testbench
// Sends directed and random byte and release requests into the receiver,
// computes each expected result with a local framing predictor and checks
// every result field by field. Both channels idle at random, and one long
// receiver stall fills the result buffer so that the input is held off.
// ----------------------------------------------------------------------------
module tb_top;
  import dfr_pkg::*;

  localparam int RANDOM_ITEMS = 60;
  localparam int STALL_CYCLES = 60;
  localparam int DRAIN_LIMIT  = 10000;

  logic clk;
  logic rst;

  dfr_in_if  rx_req ();
  dfr_out_if frame_res ();

  delimited_frame_receiver_top DUT (
    .clk       (clk),
    .rst       (rst),
    .rx_req    (rx_req),
    .frame_res (frame_res)
  );

  kind_t             model_kind;
  logic [ADDR_W-1:0] model_address;
  logic              model_held;

  dfr_result_t expected_results[$];
  int          mismatch_count;
  int          useful_items;
  bit          no_idle;
  bit          stall_request;
  logic        stall_active;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic dfr_result_t predict_frame_step(input logic m, input logic [7:0] b);
    dfr_result_t       r;
    logic [ADDR_W-1:0] addr;
    r = '0;
    if (m == MODE_RELEASE) begin
      model_held = 1'b0;
      model_kind = KIND_IDLE;
    end else if (!model_held) begin
      if (b == CHAR_LANGLE) begin
        model_kind    = KIND_ANGLE;
        model_address = '0;
      end else if (model_kind == KIND_IDLE) begin
        case (b)
          CHAR_DOLLAR: model_kind = KIND_DOLLAR;
          CHAR_HASH:   model_kind = KIND_HASH;
          CHAR_LBRACE: model_kind = KIND_BRACE;
          default:     model_kind = KIND_IDLE;
        endcase
        model_address = '0;
      end
      addr          = model_address;
      model_address = (model_address == LAST_ADDRESS) ? '0 : model_address + 1'b1;
      r.stored        = 1'b1;
      r.write_address = WRITE_ADDRESS_W'(addr);
      r.data_byte     = b;
      if ((model_kind == KIND_ANGLE && b == CHAR_RANGLE) ||
          ((model_kind == KIND_DOLLAR || model_kind == KIND_HASH) && b == CHAR_BANG) ||
          (model_kind == KIND_BRACE && b == CHAR_RBRACE)) begin
        model_held       = 1'b1;
        r.frame_complete = 1'b1;
      end
    end
    r.frame_kind_out = model_kind;
    r.frame_pending  = model_held;
    return r;
  endfunction

  task automatic send_request(input logic m, input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 31) begin
      rx_req.valid <= 1'b0;
      @(posedge clk);
    end
    rx_req.valid   <= 1'b1;
    rx_req.mode    <= m;
    rx_req.rx_byte <= b;
    @(posedge clk);
    while (!rx_req.ready) @(posedge clk);
    if (m == MODE_RELEASE || !model_held) useful_items++;
    expected_results.push_back(predict_frame_step(m, b));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(MODE_BYTE, b);
  endtask

  task automatic send_release();
    send_request(MODE_RELEASE, 8'($urandom_range(255)));
  endtask

  always @(posedge clk) begin
    if (stall_active) begin
      frame_res.ready <= 1'b0;
    end else if (no_idle) begin
      frame_res.ready <= 1'b1;
    end else begin
      frame_res.ready <= ($urandom_range(99) >= 31);
    end
  end

  initial begin
    forever begin
      wait (stall_request);
      stall_active <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clk);
      stall_active  <= 1'b0;
      stall_request = 1'b0;
    end
  end

  always @(posedge clk) begin
    dfr_result_t want;
    if (!rst && frame_res.valid && frame_res.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        if (frame_res.stored !== want.stored)
          report_mismatch($sformatf("stored %0b, expected %0b",
                                    frame_res.stored, want.stored));
        if (frame_res.write_address !== want.write_address)
          report_mismatch($sformatf("write_address %0d, expected %0d",
                                    frame_res.write_address, want.write_address));
        if (frame_res.data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte %h, expected %h",
                                    frame_res.data_byte, want.data_byte));
        if (frame_res.frame_complete !== want.frame_complete)
          report_mismatch($sformatf("frame_complete %0b, expected %0b",
                                    frame_res.frame_complete, want.frame_complete));
        if (frame_res.frame_kind_out !== want.frame_kind_out)
          report_mismatch($sformatf("frame_kind_out %0d, expected %0d",
                                    frame_res.frame_kind_out, want.frame_kind_out));
        if (frame_res.frame_pending !== want.frame_pending)
          report_mismatch($sformatf("frame_pending %0b, expected %0b",
                                    frame_res.frame_pending, want.frame_pending));
      end
    end
  end

  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_BANG);
    send_byte(CHAR_RANGLE);
    send_release();
  endtask

  task automatic test_frame_kinds();
    send_byte(CHAR_DOLLAR);
    send_byte(8'h5A);
    send_byte(CHAR_RBRACE);
    send_byte(CHAR_BANG);
    send_byte(CHAR_LANGLE);
    send_release();
    send_byte(CHAR_HASH);
    send_byte(CHAR_BANG);
    send_release();
    send_byte(CHAR_LBRACE);
    send_byte(CHAR_BANG);
    send_byte(CHAR_RBRACE);
    send_release();
  endtask

  task automatic test_angle_restart();
    send_byte(CHAR_LBRACE);
    send_byte(8'hA5);
    send_byte(CHAR_LANGLE);
    send_byte(8'h81);
    send_byte(CHAR_RANGLE);
    send_release();
  endtask

  // A frame longer than the buffer, so that the write address wraps to zero.
  task automatic test_address_wrap();
    logic [7:0] b;
    no_idle = 1'b1;
    send_byte(CHAR_DOLLAR);
    repeat (BUFFER_DEPTH + 6) begin
      do b = 8'($urandom_range(255)); while (b == CHAR_BANG || b == CHAR_LANGLE);
      send_byte(b);
    end
    send_byte(CHAR_BANG);
    send_release();
    no_idle = 1'b0;
  endtask

  // The receiver holds off while requests keep coming, so the block fills up.
  task automatic test_backpressure();
    logic [7:0] b;
    no_idle       = 1'b1;
    stall_request = 1'b1;
    send_byte(CHAR_LBRACE);
    repeat (20) begin
      do b = 8'($urandom_range(255)); while (b == CHAR_RBRACE || b == CHAR_LANGLE);
      send_byte(b);
    end
    send_byte(CHAR_RBRACE);
    send_release();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int         target;
    int         len;
    logic [7:0] start_char;
    logic [7:0] end_char;
    logic [7:0] b;
    target = useful_items + RANDOM_ITEMS;
    while (useful_items < target) begin
      if ($urandom_range(99) < 75) begin
        if (model_held || model_kind != KIND_IDLE) send_release();
        case ($urandom_range(3))
          0: begin start_char = CHAR_DOLLAR; end_char = CHAR_BANG;   end
          1: begin start_char = CHAR_HASH;   end_char = CHAR_BANG;   end
          2: begin start_char = CHAR_LBRACE; end_char = CHAR_RBRACE; end
          default: begin start_char = CHAR_LANGLE; end_char = CHAR_RANGLE; end
        endcase
        send_byte(start_char);
        len = $urandom_range(0, 12);
        repeat (len) begin
          if ($urandom_range(14) == 0) begin
            b        = CHAR_LANGLE;
            end_char = CHAR_RANGLE;
          end else begin
            do b = 8'($urandom_range(255)); while (b == end_char || b == CHAR_LANGLE);
          end
          send_byte(b);
        end
        send_byte(end_char);
        if ($urandom_range(1) == 1) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        end
        send_release();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(99) < 20) begin
            send_release();
          end else begin
            case ($urandom_range(9))
              0: b = CHAR_DOLLAR;
              1: b = CHAR_HASH;
              2: b = CHAR_LBRACE;
              3: b = CHAR_LANGLE;
              4: b = CHAR_BANG;
              5: b = CHAR_RBRACE;
              6: b = CHAR_RANGLE;
              default: b = 8'($urandom_range(255));
            endcase
            send_byte(b);
          end
        end
      end
    end
  endtask

  initial begin
    int waited;
    rst              = 1'b1;
    rx_req.valid     = 1'b0;
    rx_req.mode      = MODE_BYTE;
    rx_req.rx_byte   = 8'h00;
    frame_res.ready  = 1'b0;
    stall_active     = 1'b0;
    stall_request    = 1'b0;
    no_idle          = 1'b0;
    mismatch_count   = 0;
    useful_items     = 0;
    model_kind       = KIND_IDLE;
    model_address    = '0;
    model_held       = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_idle_bytes();
    test_frame_kinds();
    test_angle_restart();
    test_address_wrap();
    test_backpressure();
    test_random_traffic();
    rx_req.valid <= 1'b0;

    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS delimited_frame_receiver_top");
    end else begin
      $display("FAIL delimited_frame_receiver_top");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAIL delimited_frame_receiver_top");
    $finish;
  end

endmodule
